// ===== rtl/ftbh_pkg.sv =====
// Shared types, constants and the per-byte hash step for the flow tuple bucket hash.
// No dependencies; used by every module in rtl/.
package ftbh_pkg;

  // Bucket count, a power of two; the index is its low bits.
  localparam int BUCKETS     = 256;
  localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BUCKET_W    = 8;

  // Byte stream per endpoint: port, then four zero bytes, IPv6 address and pad, or IPv4 address and zeros.
  localparam int STREAM_BYTES = 24;
  localparam int STREAM_W     = STREAM_BYTES * 8;
  localparam int STAGE_BYTES  = 4;
  localparam int HASH_STAGES  = STREAM_BYTES / STAGE_BYTES;
  localparam int CNT_W        = $clog2(STREAM_BYTES + 1);
  localparam int V6_BYTES     = 22;
  localparam int V4_BYTES     = 6;

  // Hash state stays below 2^28 after every byte.
  localparam int HASH_W = 28;

  typedef struct packed {
    logic [STREAM_W-1:0] src_bytes;
    logic [STREAM_W-1:0] dst_bytes;
    logic [CNT_W-1:0]    remain;
    logic [HASH_W-1:0]   src_h;
    logic [HASH_W-1:0]   dst_h;
  } stage_t;

  // One PJW/ELF step: h = (h << 4) + b; fold the top nibble down and clear it.
  function automatic logic [HASH_W-1:0] pjw_feed(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [31:0] t;
    t = {h, 4'b0000} + {24'd0, b};
    return t[HASH_W-1:0] ^ {20'd0, t[31:28], 4'b0000};
  endfunction

endpackage

// ===== rtl/ftbh_unpack.sv =====
// Input register of the bucket hash: lays out both endpoints as byte streams.
// Depends on ftbh_pkg.
module ftbh_unpack (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   is_ipv6,
  input  logic [63:0]            src_addr_hi,
  input  logic [63:0]            src_addr_lo,
  input  logic [63:0]            dst_addr_hi,
  input  logic [63:0]            dst_addr_lo,
  input  logic [15:0]            src_port,
  input  logic [15:0]            dst_port,
  output logic                   out_valid,
  output ftbh_pkg::stage_t       out_data,
  input  logic                   out_stall
);

  ftbh_pkg::stage_t data_next;

  always_comb begin
    data_next.src_h = '0;
    data_next.dst_h = '0;
    if (is_ipv6) begin
      data_next.src_bytes = {src_port, 32'd0, src_addr_hi, src_addr_lo, 16'd0};
      data_next.dst_bytes = {dst_port, 32'd0, dst_addr_hi, dst_addr_lo, 16'd0};
      data_next.remain    = ftbh_pkg::CNT_W'(ftbh_pkg::V6_BYTES);
    end else begin
      data_next.src_bytes = {src_port, src_addr_lo[31:0], 144'd0};
      data_next.dst_bytes = {dst_port, dst_addr_lo[31:0], 144'd0};
      data_next.remain    = ftbh_pkg::CNT_W'(ftbh_pkg::V4_BYTES);
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/ftbh_hash_stage.sv =====
// One hash stage: feeds up to four bytes of each endpoint stream into its hash.
// Depends on ftbh_pkg.
module ftbh_hash_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ftbh_pkg::stage_t in_data,
  output logic             out_valid,
  output ftbh_pkg::stage_t out_data,
  input  logic             out_stall
);

  ftbh_pkg::stage_t data_next;

  always_comb begin
    logic [ftbh_pkg::HASH_W-1:0] hs;
    logic [ftbh_pkg::HASH_W-1:0] hd;
    hs = in_data.src_h;
    hd = in_data.dst_h;
    for (int j = 0; j < ftbh_pkg::STAGE_BYTES; j++) begin
      if (ftbh_pkg::CNT_W'(j) < in_data.remain) begin
        hs = ftbh_pkg::pjw_feed(hs, in_data.src_bytes[ftbh_pkg::STREAM_W-1-8*j -: 8]);
        hd = ftbh_pkg::pjw_feed(hd, in_data.dst_bytes[ftbh_pkg::STREAM_W-1-8*j -: 8]);
      end
    end
    data_next.src_h     = hs;
    data_next.dst_h     = hd;
    data_next.src_bytes = in_data.src_bytes << (8 * ftbh_pkg::STAGE_BYTES);
    data_next.dst_bytes = in_data.dst_bytes << (8 * ftbh_pkg::STAGE_BYTES);
    if (in_data.remain > ftbh_pkg::CNT_W'(ftbh_pkg::STAGE_BYTES)) begin
      data_next.remain = in_data.remain - ftbh_pkg::CNT_W'(ftbh_pkg::STAGE_BYTES);
    end else begin
      data_next.remain = '0;
    end
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/ftbh_reduce.sv =====
// Output stage: reduces both endpoint hashes to buckets and combines them.
// Depends on ftbh_pkg.
module ftbh_reduce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ftbh_pkg::stage_t              in_data,
  output logic                          out_valid,
  output logic [ftbh_pkg::BUCKET_W-1:0] bucket,
  input  logic                          out_stall
);

  logic [ftbh_pkg::BKT_W:0]    sum;
  logic [ftbh_pkg::BKT_W-1:0]  idx;

  // Power-of-two bucket count: each modulo is a mask, the sum wraps.
  assign sum = {1'b0, in_data.src_h[ftbh_pkg::BKT_W-1:0]}
             + {1'b0, in_data.dst_h[ftbh_pkg::BKT_W-1:0]};
  assign idx = sum[ftbh_pkg::BKT_W-1:0];

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      bucket <= ftbh_pkg::BUCKET_W'(idx);
    end
  end

endmodule

// ===== rtl/flow_tuple_bucket_hash.sv =====
// flow_tuple_bucket_hash: bucket index of a flow tuple from per-endpoint PJW/ELF hashes.
// Pipeline: an accepted input transaction passes to a valid bucket through
// 1 unpack register, 6 hash stages of 4 bytes and 1 reduce register.
// Throughput: one transaction per cycle while out_stall is low; every stage holds its own valid bit.
// Reset (rst, synchronous, active high) clears the valid bits only; no other state.
// Depends on ftbh_pkg, ftbh_unpack, ftbh_hash_stage, ftbh_reduce.
module flow_tuple_bucket_hash (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        is_ipv6,
  input  logic [63:0] src_addr_hi,
  input  logic [63:0] src_addr_lo,
  input  logic [63:0] dst_addr_hi,
  input  logic [63:0] dst_addr_lo,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  bucket
);

  // Pipe slot 0 is the unpack register; slot k+1 is the output of hash stage k.
  ftbh_pkg::stage_t pipe_data  [ftbh_pkg::HASH_STAGES+1];
  logic             pipe_valid [ftbh_pkg::HASH_STAGES+1];
  logic             pipe_stall [ftbh_pkg::HASH_STAGES+1];

  // Each endpoint becomes a 24-byte stream in wire order; the byte count
  // (6 for IPv4, 22 for IPv6) masks off the unused tail.
  ftbh_unpack u_unpack (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .is_ipv6     (is_ipv6),
    .src_addr_hi (src_addr_hi),
    .src_addr_lo (src_addr_lo),
    .dst_addr_hi (dst_addr_hi),
    .dst_addr_lo (dst_addr_lo),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .out_valid   (pipe_valid[0]),
    .out_data    (pipe_data[0]),
    .out_stall   (pipe_stall[0])
  );

  // Hash stages: both endpoints run side by side, four bytes per stage.
  // A stage takes a new transaction whenever its own register is empty or
  // moving on, so bubbles close up behind a stalled output.
  for (genvar k = 0; k < ftbh_pkg::HASH_STAGES; k++) begin : g_hash
    ftbh_hash_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[k]),
      .in_stall  (pipe_stall[k]),
      .in_data   (pipe_data[k]),
      .out_valid (pipe_valid[k+1]),
      .out_data  (pipe_data[k+1]),
      .out_stall (pipe_stall[k+1])
    );
  end

  // Final register: bucket = (src_h % BUCKETS + dst_h % BUCKETS) % BUCKETS.
  // It doubles as the output register, so the pipe keeps filling while a
  // finished bucket waits.
  ftbh_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pipe_valid[ftbh_pkg::HASH_STAGES]),
    .in_stall  (pipe_stall[ftbh_pkg::HASH_STAGES]),
    .in_data   (pipe_data[ftbh_pkg::HASH_STAGES]),
    .out_valid (out_valid),
    .bucket    (bucket),
    .out_stall (out_stall)
  );

endmodule
